@@ src/imgup_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// imgup_pkg
// Shared types and codes for the image upscaler: register indexes, item
// operations and the fixed field widths.
// ----------------------------------------------------------------------------
package imgup_pkg;

    // configuration register indexes
    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t REG_SOURCE_WIDTH = 2'd0;
    localparam cfg_index_t REG_INTERP_MODE  = 2'd1;
    localparam cfg_index_t REG_X_STEP       = 2'd2;
    localparam cfg_index_t REG_Y_STEP       = 2'd3;

    // configuration write data, wide enough for the step registers
    typedef logic [16:0] cfg_data_t;

    // item operations
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    // interpolation modes
    localparam logic MODE_NEAREST  = 1'b0;
    localparam logic MODE_BILINEAR = 1'b1;

    // field types
    typedef logic [7:0]  chan_t;
    typedef logic [23:0] pixel_t;    // R 23..16, G 15..8, B 7..0
    typedef logic [15:0] pix_index_t;
    typedef logic [11:0] coord_t;

    // source position: 17-bit step times 12-bit coordinate, 13.16 fixed point
    typedef logic [28:0] pos_t;
    // raster address before the range check
    typedef logic [23:0] addr_t;
    // blend weight, at most 256*256
    typedef logic [16:0] weight_t;
    // per-channel accumulator, at most 255*65536
    typedef logic [23:0] acc_t;

endpackage : imgup_pkg
`default_nettype wire

@@ src/imgup_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// imgup_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module imgup_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16,
    localparam int AddrW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AddrW-1:0] waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AddrW-1:0] raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule : imgup_ram
`default_nettype wire

@@ src/image_upscaler_nearest_bilinear_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// image_upscaler_nearest_bilinear_core
// Nearest / bilinear image scaler around one source frame store. Load words
// write a source pixel; request words return one scaled destination pixel.
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid/in_ready, operation, pixel_index,| in
//          | red_in, green_in, blue_in, dest_x, dest_y |
//  output  | out_valid/out_ready, red_out, green_out,  | out
//          | blue_out                                  |
//  config  | cfg_valid/cfg_ready, cfg_index, cfg_data  | in
//
//  A load word is written to the store at acceptance. A request goes through
//  the base, read, drain and output states before the next word is taken: the
//  four neighbours in bilinear mode, or one in nearest mode, are read one a
//  cycle through the store's single read port, each weighted as it lands.
//  The finished pixel sits in the output register; a new word is taken while
//  it waits, and a request stalls only at its end if that register is full.
//  Reset clears control and configuration; the store itself is not cleared.
//
module image_upscaler_nearest_bilinear_core #(
    parameter int STORE_DEPTH  = 65536,
    parameter int MAX_DEST_DIM = 4096
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,

    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic                    operation,
    input  wire imgup_pkg::pix_index_t   pixel_index,
    input  wire imgup_pkg::chan_t        red_in,
    input  wire imgup_pkg::chan_t        green_in,
    input  wire imgup_pkg::chan_t        blue_in,
    input  wire imgup_pkg::coord_t       dest_x,
    input  wire imgup_pkg::coord_t       dest_y,

    output logic                         out_valid,
    input  wire logic                    out_ready,
    output imgup_pkg::chan_t             red_out,
    output imgup_pkg::chan_t             green_out,
    output imgup_pkg::chan_t             blue_out,

    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire imgup_pkg::cfg_index_t   cfg_index,
    input  wire imgup_pkg::cfg_data_t    cfg_data
);

    import imgup_pkg::*;

    localparam int AddrW = $clog2(STORE_DEPTH);

    // state codes
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_BASE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]  state_reg, state_next;

    // configuration registers
    logic [8:0]  source_width_reg;
    logic        interp_mode_reg;
    logic [16:0] x_step_reg;
    logic [16:0] y_step_reg;

    // request datapath
    pos_t        posx_reg, posy_reg;
    addr_t       base_reg;
    logic [1:0]  k_reg;
    weight_t     w_reg;
    logic        rng_reg;
    logic        mac_en_reg;
    acc_t        acc_r_reg, acc_g_reg, acc_b_reg;

    // output register
    logic        out_valid_reg;
    chan_t       red_out_reg, green_out_reg, blue_out_reg;

    // store ports
    logic             st_we;
    logic [AddrW-1:0] st_waddr;
    logic [AddrW-1:0] st_raddr;
    pixel_t           st_rdata;
    logic [31:0]      load_idx_wide;

    // combinational helpers
    logic        in_acc;
    logic        req_acc;
    coord_t      dx_clamped, dy_clamped;
    addr_t       issue_addr;
    logic        issue_in_range;
    logic [8:0]  fx9, fy9, wa, wb;
    weight_t     issue_w;
    logic        last_issue;
    pixel_t      pix_masked;
    logic        out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = in_valid && in_ready;
    assign req_acc   = in_acc && (operation == OP_REQUEST);
    assign out_free  = !out_valid_reg || out_ready;

    // coordinate saturation
    assign dx_clamped = ({20'b0, dest_x} >= 32'(MAX_DEST_DIM)) ?
                        12'(MAX_DEST_DIM - 1) : dest_x;
    assign dy_clamped = ({20'b0, dest_y} >= 32'(MAX_DEST_DIM)) ?
                        12'(MAX_DEST_DIM - 1) : dest_y;

    // load path: write at acceptance, ignore indexes beyond the store
    assign load_idx_wide = {16'b0, pixel_index};
    assign st_we    = in_acc && (operation == OP_LOAD) &&
                      (load_idx_wide < 32'(STORE_DEPTH));
    assign st_waddr = load_idx_wide[AddrW-1:0];

    // neighbour address: k bit 0 steps in x, bit 1 steps one row down
    assign issue_addr = base_reg
                      + (k_reg[1] ? {15'b0, source_width_reg} : 24'd0)
                      + {23'b0, k_reg[0]};
    assign issue_in_range = ({8'b0, issue_addr} < 32'(STORE_DEPTH));
    assign st_raddr       = issue_addr[AddrW-1:0];

    // neighbour weight
    assign fx9 = {1'b0, posx_reg[15:8]};
    assign fy9 = {1'b0, posy_reg[15:8]};
    assign wa  = k_reg[0] ? fx9 : (9'd256 - fx9);
    assign wb  = k_reg[1] ? fy9 : (9'd256 - fy9);
    assign issue_w = (interp_mode_reg == MODE_BILINEAR) ?
                     17'({9'b0, wa} * {9'b0, wb}) : 17'd65536;

    assign last_issue = (interp_mode_reg == MODE_BILINEAR) ? (k_reg == 2'd3)
                                                           : (k_reg == 2'd0);

    // out-of-store neighbours read as black
    assign pix_masked = rng_reg ? st_rdata : 24'd0;

    // frame store
    imgup_ram #(
        .WIDTH (24),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata ({red_in, green_in, blue_in}),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_acc)
                begin
                    state_next = S_BASE;
                end
            end
            S_BASE:
            begin
                state_next = S_READ;
            end
            S_READ:
            begin
                if (last_issue)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            k_reg            <= 2'd0;
            mac_en_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
            source_width_reg <= 9'd256;
            interp_mode_reg  <= MODE_BILINEAR;
            x_step_reg       <= 17'd32768;
            y_step_reg       <= 17'd32768;
        end
        else
        begin
            state_reg  <= state_next;
            mac_en_reg <= (state_reg == S_READ);

            if (state_reg == S_READ)
            begin
                k_reg <= k_reg + 2'd1;
            end
            else
            begin
                k_reg <= 2'd0;
            end

            if (state_reg == S_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_SOURCE_WIDTH: source_width_reg <= cfg_data[8:0];
                    REG_INTERP_MODE:  interp_mode_reg  <= cfg_data[0];
                    REG_X_STEP:       x_step_reg       <= cfg_data;
                    REG_Y_STEP:       y_step_reg       <= cfg_data;
                    default:          ;
                endcase
            end
        end
    end

    // request datapath
    always_ff @(posedge clk)
    begin
        // source position
        if (req_acc)
        begin
            posx_reg <= 29'({12'b0, x_step_reg} * {17'b0, dx_clamped});
            posy_reg <= 29'({12'b0, y_step_reg} * {17'b0, dy_clamped});
        end

        // raster base and accumulator clear
        if (state_reg == S_BASE)
        begin
            base_reg  <= 24'({11'b0, posy_reg[28:16]} * {15'b0, source_width_reg})
                       + {11'b0, posx_reg[28:16]};
            acc_r_reg <= 24'd0;
            acc_g_reg <= 24'd0;
            acc_b_reg <= 24'd0;
        end

        // weight travels with the read in flight
        w_reg   <= issue_w;
        rng_reg <= issue_in_range;

        // weight the neighbour as it lands
        if (mac_en_reg)
        begin
            acc_r_reg <= acc_r_reg + 24'({17'b0, pix_masked[23:16]} * {8'b0, w_reg});
            acc_g_reg <= acc_g_reg + 24'({17'b0, pix_masked[15:8]}  * {8'b0, w_reg});
            acc_b_reg <= acc_b_reg + 24'({17'b0, pix_masked[7:0]}   * {8'b0, w_reg});
        end

        // result word
        if (state_reg == S_OUT && out_free)
        begin
            red_out_reg   <= acc_r_reg[23:16];
            green_out_reg <= acc_g_reg[23:16];
            blue_out_reg  <= acc_b_reg[23:16];
        end
    end

    assign out_valid = out_valid_reg;
    assign red_out   = red_out_reg;
    assign green_out = green_out_reg;
    assign blue_out  = blue_out_reg;

endmodule : image_upscaler_nearest_bilinear_core
`default_nettype wire
